/* sv/dia_pkg.sv */
package dia_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int SENSOR_BITS   = 4;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int DENSE_W       = 8;
  localparam int USE_W         = 9;
  localparam int SOURCE_W      = 64;

  typedef struct packed {
    logic [3:0]          sensor_index;
    logic [SOURCE_W-1:0] source_id;
  } req_t;

  typedef struct packed {
    logic [DENSE_W-1:0] dense_id;
    logic               newly_assigned;
    logic               table_full;
    logic [USE_W-1:0]   entries_in_use;
  } rsp_t;

  typedef struct packed {
    logic [SENSOR_BITS-1:0] sensor;
    logic [SOURCE_W-1:0]    source;
  } key_t;

endpackage

/* sv/dia_front.sv */
module dia_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dia_pkg::req_t req,
  output logic          key_valid,
  input  logic          key_ready,
  output dia_pkg::key_t key
);
  import dia_pkg::*;

  key_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  key_t       key_in;

  always_comb begin
    key_in.sensor = SENSOR_BITS'(req.sensor_index);
    key_in.source = req.source_id;
  end

  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign key_valid = (fill != 2'd0);
  assign pop       = key_valid && key_ready;
  assign key       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= key_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* sv/dia_back.sv */
module dia_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          key_valid,
  output logic          key_ready,
  input  dia_pkg::key_t key,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dia_pkg::rsp_t rsp
);
  import dia_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  key_t             store [TABLE_ENTRIES];
  logic [1:0]       state;
  key_t             cur;
  logic [CNT_W-1:0] rd_idx;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  key_t             rd_data;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic [CNT_W-1:0] count;
  logic             hit_now;
  logic             issue;
  logic             has_room;
  logic             emit;
  logic             store_wr;

  assign key_ready = (state == S_IDLE);
  assign hit_now   = cmp_vld && (rd_data == cur);
  assign issue     = (state == S_SCAN) && !hit_now && (rd_idx < count);
  assign has_room  = (count < CNT_W'(TABLE_ENTRIES));
  assign emit      = (state == S_DONE) && (!rsp_valid || !rsp_stall);
  assign store_wr  = emit && !found && has_room;

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= store[rd_idx[IDX_W-1:0]];
    end
    if (store_wr) begin
      store[count[IDX_W-1:0]] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_vld   <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (key_valid) begin
            cur     <= key;
            rd_idx  <= '0;
            cmp_vld <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_now) begin
            found     <= 1'b1;
            found_idx <= cmp_idx;
            cmp_vld   <= 1'b0;
            state     <= S_DONE;
          end else if (issue) begin
            cmp_idx <= rd_idx[IDX_W-1:0];
            cmp_vld <= 1'b1;
            rd_idx  <= rd_idx + CNT_W'(1);
          end else begin
            found   <= 1'b0;
            cmp_vld <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (emit) begin
            state <= S_IDLE;
            if (found) begin
              rsp.dense_id       <= DENSE_W'(found_idx);
              rsp.newly_assigned <= 1'b0;
              rsp.table_full     <= 1'b0;
              rsp.entries_in_use <= USE_W'(count);
            end else if (has_room) begin
              rsp.dense_id       <= DENSE_W'(count);
              rsp.newly_assigned <= 1'b1;
              rsp.table_full     <= 1'b0;
              rsp.entries_in_use <= USE_W'(count + CNT_W'(1));
              count              <= count + CNT_W'(1);
            end else begin
              rsp.dense_id       <= '0;
              rsp.newly_assigned <= 1'b0;
              rsp.table_full     <= 1'b1;
              rsp.entries_in_use <= USE_W'(count);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/dense_id_assignment_table_top.sv */
// channel   direction  handshake                  payload
// req       in         req_valid / req_stall      dia_pkg::req_t
// rsp       out        rsp_valid / rsp_stall      dia_pkg::rsp_t
//
// a lookup scans the n entries in use (256 at most), one entry per cycle, through the
// read port of the pair store
// the two-deep request queue keeps accepting while a lookup runs, until it holds two requests
// rst clears the entry count and handshake state; store contents are kept
// a stalled result holds the back end in the final step of the next lookup until taken
module dense_id_assignment_table_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dia_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dia_pkg::rsp_t rsp
);
  import dia_pkg::*;

  logic key_valid;
  logic key_ready;
  key_t key;

  dia_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key       (key)
  );

  dia_back u_back (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .key       (key),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

/* sv/dia_checker.sv */
module dia_props (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input dia_pkg::rsp_t rsp
);
  import dia_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_new_not_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.newly_assigned && rsp.table_full))
    else $error("new and full at once");

  a_full_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.table_full |->
      rsp.entries_in_use == USE_W'(TABLE_ENTRIES) && rsp.dense_id == '0)
    else $error("full response malformed");

  a_new_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.newly_assigned |->
      USE_W'(rsp.dense_id) + USE_W'(1) == rsp.entries_in_use)
    else $error("new dense number not last entry");

endmodule

bind dense_id_assignment_table_top dia_props u_dia_props (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
